### src/mrpbr_pkg.sv
// package: shared constants, codes and beat types of the repeat-pattern byte reader
`timescale 1ns / 1ps

package mrpbr_pkg;

    // store geometry
    localparam int STORE_DEPTH = 131072;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int FILL_W      = $clog2(STORE_DEPTH + 1);
    localparam int POS_W       = 17;
    // cursor reaches a marker address plus the header length
    localparam int CUR_W       = ($clog2(STORE_DEPTH + 4) > POS_W) ?
                                 $clog2(STORE_DEPTH + 4) : POS_W;

    // command queue between front and back
    localparam int QDEPTH = 2;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // stream encoding
    localparam logic [7:0] ESC_MARK    = 8'hFE;
    localparam logic [7:0] GROUP_MASK  = 8'h7F;
    localparam logic [7:0] MORE_MASK   = 8'h80;
    localparam int         REP_HDR_LEN = 4;

    // request codes on the input beat
    localparam logic [1:0] REQ_LOAD   = 2'd0;
    localparam logic [1:0] REQ_READ   = 2'd1;
    localparam logic [1:0] REQ_DELAY  = 2'd2;
    localparam logic [1:0] REQ_SETPOS = 2'd3;

    // command kinds held in the queue
    localparam logic [1:0] CMD_LOAD   = 2'd0;
    localparam logic [1:0] CMD_READ   = 2'd1;
    localparam logic [1:0] CMD_DELAY  = 2'd2;
    localparam logic [1:0] CMD_SETPOS = 2'd3;

    typedef struct packed {
        logic [1:0]       req_type;
        logic [7:0]       load_byte;
        logic [POS_W-1:0] position;
    } req_t;

    typedef struct packed {
        logic [31:0] value;
        logic        underrun;
    } rsp_t;

    typedef struct packed {
        logic [1:0]       kind;
        logic [7:0]       load_byte;
        logic [POS_W-1:0] position;
    } cmd_t;

    // queue head as seen by the back end
    typedef struct packed {
        logic valid;
        cmd_t cmd;
    } fq_t;

endpackage

### src/mrpbr_ram.sv
// generic simple dual-port ram with registered read
`timescale 1ns / 1ps

module mrpbr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

### src/mrpbr_front.sv
// front end: accepts request beats, classifies them and queues commands
`timescale 1ns / 1ps

module mrpbr_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  mrpbr_pkg::req_t    req,
    input  logic               pop,
    output mrpbr_pkg::fq_t     fq
);

    mrpbr_pkg::cmd_t                 q_reg [mrpbr_pkg::QDEPTH];
    logic [mrpbr_pkg::QPTR_W-1:0]    wr_ptr_reg;
    logic [mrpbr_pkg::QPTR_W-1:0]    wr_ptr_next;
    logic [mrpbr_pkg::QPTR_W-1:0]    rd_ptr_reg;
    logic [mrpbr_pkg::QPTR_W-1:0]    rd_ptr_next;
    logic [mrpbr_pkg::QCNT_W-1:0]    cnt_reg;
    logic [mrpbr_pkg::QCNT_W-1:0]    cnt_next;
    logic                            push;
    logic                            do_pop;
    mrpbr_pkg::cmd_t                 cmd_in;

    // classify the request into a command
    always_comb
    begin
        cmd_in.load_byte = req.load_byte;
        cmd_in.position  = req.position;
        unique case (req.req_type)
            mrpbr_pkg::REQ_LOAD:   cmd_in.kind = mrpbr_pkg::CMD_LOAD;
            mrpbr_pkg::REQ_READ:   cmd_in.kind = mrpbr_pkg::CMD_READ;
            mrpbr_pkg::REQ_DELAY:  cmd_in.kind = mrpbr_pkg::CMD_DELAY;
            mrpbr_pkg::REQ_SETPOS: cmd_in.kind = mrpbr_pkg::CMD_SETPOS;
            default:               cmd_in.kind = mrpbr_pkg::CMD_LOAD;
        endcase
    end

    // queue handshake
    assign busy     = (cnt_reg == mrpbr_pkg::QCNT_W'(mrpbr_pkg::QDEPTH));
    assign push     = start && !busy;
    assign do_pop   = pop && (cnt_reg != '0);
    assign fq.valid = (cnt_reg != '0);
    assign fq.cmd   = q_reg[rd_ptr_reg];

    // pointer and count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == mrpbr_pkg::QPTR_W'(mrpbr_pkg::QDEPTH - 1)) ?
                          '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == mrpbr_pkg::QPTR_W'(mrpbr_pkg::QDEPTH - 1)) ?
                          '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !do_pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_pop && !push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // queue storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= cmd_in;
        end
    end

endmodule

### src/mrpbr_back.sv
// back end: byte store, decode sequencer and result register
`timescale 1ns / 1ps

module mrpbr_back (
    input  logic             clk,
    input  logic             rst_n,
    input  mrpbr_pkg::fq_t   fq,
    output logic             pop,
    output logic             done,
    output mrpbr_pkg::rsp_t  rsp
);

    localparam int CUR_W  = mrpbr_pkg::CUR_W;
    localparam int ADDR_W = mrpbr_pkg::ADDR_W;
    localparam int FILL_W = mrpbr_pkg::FILL_W;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_NEXT   = 3'd1;
    localparam logic [2:0] ST_REP_D  = 3'd2;
    localparam logic [2:0] ST_MARK_D = 3'd3;
    localparam logic [2:0] ST_HI_D   = 3'd4;
    localparam logic [2:0] ST_LO_D   = 3'd5;
    localparam logic [2:0] ST_CNT_D  = 3'd6;
    localparam logic [2:0] ST_SRC_D  = 3'd7;

    logic [2:0]        state_reg,  state_next;
    logic [FILL_W-1:0] fill_reg,   fill_next;
    // committed cursor
    logic [CUR_W-1:0]  rd_reg,     rd_next;
    logic              act_reg,    act_next;
    logic [CUR_W-1:0]  raddr_reg,  raddr_next;
    logic [7:0]        left_reg,   left_next;
    // working cursor for the request in flight
    logic [CUR_W-1:0]  w_rd_reg,    w_rd_next;
    logic              w_act_reg,   w_act_next;
    logic [CUR_W-1:0]  w_raddr_reg, w_raddr_next;
    logic [7:0]        w_left_reg,  w_left_next;
    logic [31:0]       acc_reg,     acc_next;
    logic              delay_reg,   delay_next;
    // repeat header fields
    logic [7:0]        hi_reg,     hi_next;
    logic [7:0]        lo_reg,     lo_next;
    logic [7:0]        cnt_reg,    cnt_next;
    logic [CUR_W-1:0]  src_reg,    src_next;
    // result beat
    logic              done_reg,   done_next;
    mrpbr_pkg::rsp_t   rsp_reg,    rsp_next;

    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [7:0]        ram_wdata;
    logic              ram_re;
    logic [ADDR_W-1:0] ram_raddr;
    logic [7:0]        ram_rdata;

    logic [CUR_W-1:0]  fill_ext;
    logic [CUR_W-1:0]  mark_p1;
    logic [CUR_W-1:0]  mark_p2;
    logic [CUR_W-1:0]  mark_p3;
    logic [CUR_W-1:0]  rep_dist;
    logic [CUR_W-1:0]  src_calc;
    logic [7:0]        cnt_eff;
    logic [7:0]        left_new;
    logic              got;
    logic [7:0]        gbyte;
    logic [7:0]        gmasked;
    logic [31:0]       acc_new;
    logic              fail;

    mrpbr_ram #(
        .WIDTH (8),
        .DEPTH (mrpbr_pkg::STORE_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // address helpers around the marker
    assign fill_ext = CUR_W'(fill_reg);
    assign mark_p1  = w_rd_reg + CUR_W'(1);
    assign mark_p2  = w_rd_reg + CUR_W'(2);
    assign mark_p3  = w_rd_reg + CUR_W'(3);
    assign rep_dist = CUR_W'({hi_reg, lo_reg});
    assign src_calc = w_rd_reg - rep_dist;
    assign cnt_eff  = (cnt_reg == 8'd0) ? 8'd1 : cnt_reg;
    assign left_new = cnt_eff - 8'd1;
    assign gmasked  = gbyte & mrpbr_pkg::GROUP_MASK;
    assign acc_new  = {acc_reg[24:0], gmasked[6:0]};

    // decode sequencer
    always_comb
    begin
        state_next   = state_reg;
        fill_next    = fill_reg;
        rd_next      = rd_reg;
        act_next     = act_reg;
        raddr_next   = raddr_reg;
        left_next    = left_reg;
        w_rd_next    = w_rd_reg;
        w_act_next   = w_act_reg;
        w_raddr_next = w_raddr_reg;
        w_left_next  = w_left_reg;
        acc_next     = acc_reg;
        delay_next   = delay_reg;
        hi_next      = hi_reg;
        lo_next      = lo_reg;
        cnt_next     = cnt_reg;
        src_next     = src_reg;
        done_next    = 1'b0;
        rsp_next     = rsp_reg;
        ram_we       = 1'b0;
        ram_waddr    = fill_reg[ADDR_W-1:0];
        ram_wdata    = fq.cmd.load_byte;
        ram_re       = 1'b0;
        ram_raddr    = w_rd_reg[ADDR_W-1:0];
        pop          = 1'b0;
        got          = 1'b0;
        gbyte        = ram_rdata;
        fail         = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (fq.valid)
                begin
                    pop = 1'b1;
                    unique case (fq.cmd.kind)
                        mrpbr_pkg::CMD_LOAD:
                        begin
                            if (fill_reg != FILL_W'(mrpbr_pkg::STORE_DEPTH))
                            begin
                                ram_we    = 1'b1;
                                fill_next = fill_reg + 1'b1;
                            end
                        end
                        mrpbr_pkg::CMD_SETPOS:
                        begin
                            rd_next  = CUR_W'(fq.cmd.position);
                            act_next = 1'b0;
                        end
                        mrpbr_pkg::CMD_READ, mrpbr_pkg::CMD_DELAY:
                        begin
                            w_rd_next    = rd_reg;
                            w_act_next   = act_reg;
                            w_raddr_next = raddr_reg;
                            w_left_next  = left_reg;
                            acc_next     = '0;
                            delay_next   = (fq.cmd.kind == mrpbr_pkg::CMD_DELAY);
                            state_next   = ST_NEXT;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_NEXT:
            begin
                if (w_act_reg)
                begin
                    if (w_raddr_reg < fill_ext)
                    begin
                        ram_re     = 1'b1;
                        ram_raddr  = w_raddr_reg[ADDR_W-1:0];
                        state_next = ST_REP_D;
                    end
                    else
                    begin
                        fail = 1'b1;
                    end
                end
                else if (w_rd_reg < fill_ext)
                begin
                    ram_re     = 1'b1;
                    ram_raddr  = w_rd_reg[ADDR_W-1:0];
                    state_next = ST_MARK_D;
                end
                else
                begin
                    fail = 1'b1;
                end
            end
            ST_REP_D:
            begin
                // replayed raw byte
                got          = 1'b1;
                w_raddr_next = w_raddr_reg + CUR_W'(1);
                w_left_next  = w_left_reg - 8'd1;
                if (w_left_reg == 8'd1)
                begin
                    w_act_next = 1'b0;
                end
            end
            ST_MARK_D:
            begin
                if (ram_rdata != mrpbr_pkg::ESC_MARK)
                begin
                    got       = 1'b1;
                    w_rd_next = mark_p1;
                end
                else if (mark_p1 < fill_ext)
                begin
                    ram_re     = 1'b1;
                    ram_raddr  = mark_p1[ADDR_W-1:0];
                    state_next = ST_HI_D;
                end
                else
                begin
                    fail = 1'b1;
                end
            end
            ST_HI_D:
            begin
                if (ram_rdata == mrpbr_pkg::ESC_MARK)
                begin
                    // escaped literal marker
                    got       = 1'b1;
                    w_rd_next = mark_p2;
                end
                else if (mark_p2 < fill_ext)
                begin
                    hi_next    = ram_rdata;
                    ram_re     = 1'b1;
                    ram_raddr  = mark_p2[ADDR_W-1:0];
                    state_next = ST_LO_D;
                end
                else
                begin
                    fail = 1'b1;
                end
            end
            ST_LO_D:
            begin
                lo_next = ram_rdata;
                if (mark_p3 < fill_ext)
                begin
                    ram_re     = 1'b1;
                    ram_raddr  = mark_p3[ADDR_W-1:0];
                    state_next = ST_CNT_D;
                end
                else
                begin
                    fail = 1'b1;
                end
            end
            ST_CNT_D:
            begin
                cnt_next = ram_rdata;
                if (rep_dist > w_rd_reg)
                begin
                    fail = 1'b1;
                end
                else
                begin
                    // source lies at or below the marker, so it is always loaded
                    src_next   = src_calc;
                    ram_re     = 1'b1;
                    ram_raddr  = src_calc[ADDR_W-1:0];
                    state_next = ST_SRC_D;
                end
            end
            ST_SRC_D:
            begin
                // first byte of a repeat
                got          = 1'b1;
                w_rd_next    = w_rd_reg + CUR_W'(mrpbr_pkg::REP_HDR_LEN);
                w_left_next  = left_new;
                w_act_next   = (left_new != 8'd0);
                w_raddr_next = src_reg + CUR_W'(1);
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // failed request leaves the committed cursor untouched
        if (fail)
        begin
            done_next         = 1'b1;
            rsp_next.value    = '0;
            rsp_next.underrun = 1'b1;
            state_next        = ST_IDLE;
        end

        // a decoded byte either continues a delay or finishes the request
        if (got)
        begin
            if (delay_reg && ((gbyte & mrpbr_pkg::MORE_MASK) != 8'd0))
            begin
                acc_next   = acc_new;
                state_next = ST_NEXT;
            end
            else
            begin
                done_next         = 1'b1;
                rsp_next.value    = delay_reg ? acc_new : {24'd0, gbyte};
                rsp_next.underrun = 1'b0;
                rd_next           = w_rd_next;
                act_next          = w_act_next;
                raddr_next        = w_raddr_next;
                left_next         = w_left_next;
                state_next        = ST_IDLE;
            end
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            fill_reg  <= '0;
            rd_reg    <= '0;
            act_reg   <= 1'b0;
            raddr_reg <= '0;
            left_reg  <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            fill_reg  <= fill_next;
            rd_reg    <= rd_next;
            act_reg   <= act_next;
            raddr_reg <= raddr_next;
            left_reg  <= left_next;
            done_reg  <= done_next;
        end
    end

    // working registers
    always_ff @(posedge clk)
    begin
        w_rd_reg    <= w_rd_next;
        w_act_reg   <= w_act_next;
        w_raddr_reg <= w_raddr_next;
        w_left_reg  <= w_left_next;
        acc_reg     <= acc_next;
        delay_reg   <= delay_next;
        hi_reg      <= hi_next;
        lo_reg      <= lo_next;
        cnt_reg     <= cnt_next;
        src_reg     <= src_next;
        rsp_reg     <= rsp_next;
    end

    assign done = done_reg;
    assign rsp  = rsp_reg;

endmodule

### src/midi_repeat_pattern_byte_reader_top.sv
// top level: front end, command queue and decode back end of the byte reader
// results: a read gives done when a plain byte, escaped literal, repeat start or replayed
//   byte is decoded; a delay read goes on through each further byte while the more bit
//   is set; a failed read ends at the first missing byte or at a distance past its marker
// throughput: loads and position sets retire one a cycle while no read holds the back
//   end; the receiver cannot stall results
// reset clears the queue, fill count, cursor and repeat state; store contents stay
`timescale 1ns / 1ps

module midi_repeat_pattern_byte_reader_top (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  mrpbr_pkg::req_t  req,
    output logic             done,
    output mrpbr_pkg::rsp_t  rsp
);

    mrpbr_pkg::fq_t fq;
    logic           pop;

    // accept and queue request beats
    mrpbr_front u_front (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .req   (req),
        .pop   (pop),
        .fq    (fq)
    );

    // carry out queued commands
    mrpbr_back u_back (
        .clk   (clk),
        .rst_n (rst_n),
        .fq    (fq),
        .pop   (pop),
        .done  (done),
        .rsp   (rsp)
    );

    // an accepted beat is waiting in the queue on the next cycle
    a_accept_queued: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> fq.valid)
        else $error("accepted beat not visible in the queue");

    // the sequencer never gives two results back to back
    a_no_back_to_back: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("two results in consecutive cycles");

    // an underrun result carries a zero value
    a_underrun_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && rsp.underrun) |-> (rsp.value == 32'd0))
        else $error("underrun result with nonzero value");

endmodule

### tb/sv/testbench.sv
// testbench: drives load, read, delay and seek beats into the byte reader and checks each result
`timescale 1ns / 1ps

module testbench;

    localparam int MAX_SHOWN     = 10;
    localparam int RANDOM_ITEMS  = 1600;
    localparam int SETTLE_CYCLES = 32;
    localparam int POS_MAX       = (1 << mrpbr_pkg::POS_W) - 1;

    // read cursor of the stream: main pointer plus replay state
    typedef struct {
        int unsigned rd;
        bit          act;
        int unsigned src;
        bit [7:0]    left;
    } cursor_t;

    logic            clk;
    logic            rst_n;
    logic            start;
    logic            busy;
    logic            done;
    mrpbr_pkg::req_t req;
    mrpbr_pkg::rsp_t rsp;

    // behavioral copy of the store and the committed cursor
    bit [7:0]    stream_mem [mrpbr_pkg::STORE_DEPTH];
    int unsigned stream_fill;
    cursor_t     read_pos;

    mrpbr_pkg::rsp_t expected_q [$];
    mrpbr_pkg::rsp_t head_rsp;
    int unsigned     fail_count;
    int unsigned     items_sent;
    bit              no_idle;

    midi_repeat_pattern_byte_reader_top dut (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .req   (req),
        .done  (done),
        .rsp   (rsp)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // hard limit on run time
    initial
    begin
        #60_000_000;
        $display("Test completed with failures");
        $finish;
    end

    // raw store access, fails past the loaded bytes
    function automatic bit stream_byte(input int unsigned a, output bit [7:0] b);
        b = 8'h00;
        if (a >= stream_fill || a >= mrpbr_pkg::STORE_DEPTH)
            return 1'b0;
        b = stream_mem[a];
        return 1'b1;
    endfunction

    // next decoded byte, advancing a working copy of the cursor
    function automatic bit decode_next(inout cursor_t c, output bit [7:0] b);
        bit [7:0]    x;
        bit [7:0]    nxt;
        bit [7:0]    lo;
        bit [7:0]    cnt;
        int unsigned m;
        int unsigned rep_dist;
        int unsigned src;
        b = 8'h00;
        // replay in progress: raw bytes, no escape handling
        if (c.act)
        begin
            if (!stream_byte(c.src, x))
                return 1'b0;
            c.src++;
            c.left = c.left - 8'd1;
            if (c.left == 8'd0)
                c.act = 1'b0;
            b = x;
            return 1'b1;
        end
        m = c.rd;
        if (!stream_byte(m, x))
            return 1'b0;
        if (x != mrpbr_pkg::ESC_MARK)
        begin
            c.rd = m + 1;
            b = x;
            return 1'b1;
        end
        if (!stream_byte(m + 1, nxt))
            return 1'b0;
        // doubled escape is a literal escape byte
        if (nxt == mrpbr_pkg::ESC_MARK)
        begin
            c.rd = m + 2;
            b = mrpbr_pkg::ESC_MARK;
            return 1'b1;
        end
        // repeat header: distance high, distance low, count
        if (!stream_byte(m + 2, lo) || !stream_byte(m + 3, cnt))
            return 1'b0;
        rep_dist = {nxt, lo};
        if (rep_dist > m)
            return 1'b0;
        src = m - rep_dist;
        if (!stream_byte(src, x))
            return 1'b0;
        if (cnt == 8'd0)
            cnt = 8'd1;
        c.rd   = m + mrpbr_pkg::REP_HDR_LEN;
        c.left = cnt - 8'd1;
        c.act  = (c.left != 8'd0);
        c.src  = src + 1;
        b = x;
        return 1'b1;
    endfunction

    // apply one accepted beat to the model and queue its result
    function automatic void apply_request(input mrpbr_pkg::req_t r);
        cursor_t         c;
        bit [7:0]        b;
        bit [31:0]       val;
        bit              ok;
        mrpbr_pkg::rsp_t res;
        case (r.req_type)
            mrpbr_pkg::REQ_LOAD:
            begin
                if (stream_fill < mrpbr_pkg::STORE_DEPTH)
                begin
                    stream_mem[stream_fill] = r.load_byte;
                    stream_fill++;
                end
            end
            mrpbr_pkg::REQ_SETPOS:
                read_pos = '{rd: r.position, act: 1'b0, src: 0, left: 8'd0};
            default:
            begin
                c   = read_pos;
                val = 32'd0;
                if (r.req_type == mrpbr_pkg::REQ_READ)
                begin
                    ok  = decode_next(c, b);
                    val = {24'd0, b};
                end
                else
                begin
                    // delay: 7-bit groups, msb first, while the more bit is set
                    do
                    begin
                        ok = decode_next(c, b);
                        if (ok)
                            val = (val << 7) | {25'd0, b[6:0]};
                    end while (ok && b[7]);
                end
                // failed reads leave the cursor untouched
                if (ok)
                begin
                    read_pos     = c;
                    res.value    = val;
                    res.underrun = 1'b0;
                end
                else
                begin
                    res.value    = 32'd0;
                    res.underrun = 1'b1;
                end
                expected_q.push_back(res);
            end
        endcase
    endfunction

    // idle length before a beat: mostly none or short, a few long
    function automatic int unsigned pick_gap();
        int unsigned r;
        if (no_idle)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // present one beat and hold it until the block takes it
    task automatic send_beat(input logic [1:0] kind, input logic [7:0] data,
                             input int unsigned pos, input int unsigned gap);
        mrpbr_pkg::req_t r;
        r.req_type  = kind;
        r.load_byte = data;
        r.position  = pos[mrpbr_pkg::POS_W-1:0];
        @(negedge clk);
        if (gap != 0)
        begin
            start <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        start <= 1'b1;
        req   <= r;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        apply_request(r);
        items_sent++;
    endtask

    task automatic do_load(input logic [7:0] data);
        send_beat(mrpbr_pkg::REQ_LOAD, data, $urandom_range(0, POS_MAX), pick_gap());
    endtask

    task automatic do_read(input logic [1:0] kind);
        send_beat(kind, 8'($urandom), $urandom_range(0, POS_MAX), pick_gap());
    endtask

    task automatic do_seek(input int unsigned pos);
        send_beat(mrpbr_pkg::REQ_SETPOS, 8'($urandom), pos, pick_gap());
    endtask

    // hold off the sender until every pending result is back
    task automatic wait_all_results();
        @(negedge clk);
        start <= 1'b0;
        while (expected_q.size() != 0)
            @(posedge clk);
    endtask

    task automatic report_failure(input string what, input mrpbr_pkg::rsp_t want,
                                  input mrpbr_pkg::rsp_t got);
        fail_count++;
        if (fail_count <= MAX_SHOWN)
            $display("%0t: %s: expected value %h underrun %b, got value %h underrun %b",
                     $realtime, what, want.value, want.underrun, got.value, got.underrun);
    endtask

    // result checker
    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && done !== 1'b0)
        begin
            if (expected_q.size() == 0)
                report_failure("result with nothing pending", '0, rsp);
            else
            begin
                head_rsp = expected_q.pop_front();
                if (rsp.value !== head_rsp.value)
                    report_failure("value mismatch", head_rsp, rsp);
                else if (rsp.underrun !== head_rsp.underrun)
                    report_failure("underrun mismatch", head_rsp, rsp);
            end
        end
    end

    // reads on an empty store
    task automatic test_empty_store();
        do_read(mrpbr_pkg::REQ_READ);
        do_read(mrpbr_pkg::REQ_DELAY);
    endtask

    // literal bytes, escaped escape, repeat and zero-count repeat
    task automatic test_escape_and_repeat();
        do_load(8'h00);
        do_load(8'hFF);
        do_load(8'h7F);
        do_load(mrpbr_pkg::ESC_MARK);
        do_load(mrpbr_pkg::ESC_MARK);
        // repeat of 3 from address 0
        do_load(mrpbr_pkg::ESC_MARK);
        do_load(8'h00);
        do_load(8'h05);
        do_load(8'h03);
        // zero count acts as one, source is address 7
        do_load(mrpbr_pkg::ESC_MARK);
        do_load(8'h00);
        do_load(8'h02);
        do_load(8'h00);
        do_seek(0);
        do_read(mrpbr_pkg::REQ_READ);
        do_read(mrpbr_pkg::REQ_DELAY);
        do_read(mrpbr_pkg::REQ_READ);
        do_read(mrpbr_pkg::REQ_READ);
        do_read(mrpbr_pkg::REQ_DELAY);
        do_read(mrpbr_pkg::REQ_READ);
        do_read(mrpbr_pkg::REQ_READ);
    endtask

    // distance past the marker and a seek beyond the loaded bytes
    task automatic test_out_of_range();
        do_load(mrpbr_pkg::ESC_MARK);
        do_load(8'hFF);
        do_load(8'hFF);
        do_load(8'h01);
        do_seek(13);
        do_read(mrpbr_pkg::REQ_READ);
        do_seek(POS_MAX);
        do_read(mrpbr_pkg::REQ_READ);
        wait_all_results();
    endtask

    // append a stream segment made of mostly valid tokens
    task automatic load_segment(input int unsigned n_tok);
        int unsigned r;
        int unsigned m;
        int unsigned rep_dist;
        int unsigned cnt;
        bit [7:0]    d;
        repeat (n_tok)
        begin
            r = $urandom_range(0, 99);
            m = stream_fill;
            if (r < 55)
            begin
                d = 8'($urandom);
                do_load(d);
                if (d == mrpbr_pkg::ESC_MARK)
                    do_load(mrpbr_pkg::ESC_MARK);
            end
            else if (r < 68)
            begin
                do_load(mrpbr_pkg::ESC_MARK);
                do_load(mrpbr_pkg::ESC_MARK);
            end
            else if (r < 92)
            begin
                // valid repeat, mostly short
                rep_dist = (m < 600) ? $urandom_range(0, m) : $urandom_range(0, 600);
                if ($urandom_range(0, 7) == 0)
                    rep_dist = $urandom_range(0, (m > 65000) ? 65000 : m);
                r = $urandom_range(0, 99);
                if (r < 10)
                    cnt = 0;
                else if (r < 85)
                    cnt = $urandom_range(1, 6);
                else if (r < 95)
                    cnt = $urandom_range(7, 40);
                else
                    cnt = $urandom_range(41, 255);
                do_load(mrpbr_pkg::ESC_MARK);
                do_load(rep_dist[15:8]);
                do_load(rep_dist[7:0]);
                do_load(cnt[7:0]);
            end
            else
            begin
                // broken: distance past the marker, or a dangling escape
                do_load(mrpbr_pkg::ESC_MARK);
                if ($urandom_range(0, 1) == 0)
                begin
                    rep_dist = m + 1 + $urandom_range(0, 200);
                    do_load(rep_dist[15:8]);
                    do_load(rep_dist[7:0]);
                    do_load(8'($urandom));
                end
            end
        end
    endtask

    // segments loaded and then decoded, with seeks and stray loads
    task automatic test_random_traffic();
        int unsigned target;
        int unsigned seg_start;
        int unsigned r;
        target = items_sent + RANDOM_ITEMS;
        while (items_sent < target)
        begin
            no_idle   = ($urandom_range(0, 5) == 0);
            seg_start = stream_fill;
            load_segment($urandom_range(2, 12));
            r = $urandom_range(0, 99);
            if (r < 70)
                do_seek(seg_start);
            else if (r < 85)
                do_seek($urandom_range(0, stream_fill));
            else if (r < 92)
                do_seek($urandom_range(0, POS_MAX));
            repeat ($urandom_range(1, 16))
            begin
                r = $urandom_range(0, 99);
                if (r < 60)
                    do_read(mrpbr_pkg::REQ_READ);
                else if (r < 88)
                    do_read(mrpbr_pkg::REQ_DELAY);
                else if (r < 94)
                    do_seek($urandom_range(seg_start, stream_fill));
                else
                    do_load(8'($urandom));
            end
            if ($urandom_range(0, 9) == 0)
                wait_all_results();
        end
        no_idle = 1'b0;
    endtask

    // test sequence
    initial
    begin
        rst_n       = 1'b0;
        start       = 1'b0;
        req         = '0;
        fail_count  = 0;
        items_sent  = 0;
        no_idle     = 1'b0;
        stream_fill = 0;
        read_pos    = '{rd: 0, act: 1'b0, src: 0, left: 8'd0};
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_empty_store();
        test_escape_and_repeat();
        test_out_of_range();
        test_random_traffic();

        wait_all_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

### sim.f
src/mrpbr_pkg.sv
src/mrpbr_ram.sv
src/mrpbr_front.sv
src/mrpbr_back.sv
src/midi_repeat_pattern_byte_reader_top.sv
tb/sv/testbench.sv
